/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/crp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg: constants for the controller response parser
// Command and byte codes, expectation kinds, parser states and reported value
// kinds.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int unsigned ICON_ENTRIES_DEF  = 256;
	localparam int unsigned EVENT_ENTRIES_DEF = 128;

	localparam int unsigned ENTRY_W = 9;
	localparam int unsigned REC_W   = 4;
	localparam int unsigned SYNC_W  = 3;

	typedef logic [7:0]         byte_t;
	typedef logic [2:0]         expect_t;
	typedef logic [3:0]         parse_t;
	typedef logic [2:0]         vkind_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [REC_W-1:0]   rec_t;
	typedef logic [SYNC_W-1:0]  sync_t;

	localparam logic OP_BYTE       = 1'b0;
	localparam logic OP_SET_EXPECT = 1'b1;

	localparam byte_t ALL_ON       = 8'hFF;
	localparam sync_t SYNC_MIN     = 3'd6;
	localparam sync_t SYNC_MAX     = 3'd7;
	localparam rec_t  RECORD_BYTES = 4'd8;

	localparam expect_t EX_IDLE       = 3'd0;
	localparam expect_t EX_ACK        = 3'd1;
	localparam expect_t EX_ACK_UPLOAD = 3'd2;
	localparam expect_t EX_CLOCK      = 3'd3;
	localparam expect_t EX_UPLOAD     = 3'd4;
	localparam expect_t EX_GRAPHICS   = 3'd5;
	localparam expect_t EX_EVENTS     = 3'd6;

	localparam parse_t PS_IDLE   = 4'd0;
	localparam parse_t PS_SYNC   = 4'd1;
	localparam parse_t PS_STATUS = 4'd2;
	localparam parse_t PS_HOUSE  = 4'd3;
	localparam parse_t PS_UNITS1 = 4'd4;
	localparam parse_t PS_UNITS2 = 4'd5;
	localparam parse_t PS_BASE   = 4'd6;
	localparam parse_t PS_MINUTE = 4'd7;
	localparam parse_t PS_HOUR   = 4'd8;
	localparam parse_t PS_DAY    = 4'd9;
	localparam parse_t PS_ICON1  = 4'd10;
	localparam parse_t PS_ICON2  = 4'd11;
	localparam parse_t PS_EVENT1 = 4'd12;
	localparam parse_t PS_EVENT8 = 4'd13;

	localparam vkind_t VK_NONE   = 3'd0;
	localparam vkind_t VK_MINUTE = 3'd1;
	localparam vkind_t VK_HOUR   = 3'd2;
	localparam vkind_t VK_DAY    = 3'd3;
	localparam vkind_t VK_HOUSE  = 3'd4;

endpackage
`default_nettype wire

/* rtl/core/controller_response_parser.sv */
// Usage: each input word is either a command (opcode 1) that sets the kind of
// response awaited, or one received serial byte (opcode 0). Every received
// byte yields one result word; a command yields none.
// Both channels use valid/stall; a word moves on a rising edge with valid high
// and stall low. Input words land in a register and are parsed from there; the
// result enters an output register once it is free and sits there until taken.
// Throughput: one word per cycle while a held result is not stalled.
// in_stall rises only while a result is held by out_stall and the input
// register is already full, so backpressure passes through combinationally.
// Reset (arst_n low) empties both registers and returns the parser to idle
// with no response awaited and all counters cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// controller_response_parser: serial response parser
// Finds the sync run, reports the status byte and clock/house code fields,
// skips icon and event tables and flags response completion.
// ----------------------------------------------------------------------------
module controller_response_parser #(
	parameter int unsigned ICON_ENTRIES  = crp_pkg::ICON_ENTRIES_DEF,
	parameter int unsigned EVENT_ENTRIES = crp_pkg::EVENT_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             opcode,
	input  wire crp_pkg::byte_t   data_byte,
	input  wire crp_pkg::expect_t expect_kind,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  status_valid,
	output crp_pkg::byte_t        status_byte,
	output crp_pkg::vkind_t       value_kind,
	output crp_pkg::byte_t        value_data,
	output logic                  complete
);
	import crp_pkg::*;

	localparam entry_t ICON_LIMIT  = ENTRY_W'(ICON_ENTRIES);
	localparam entry_t EVENT_LIMIT = ENTRY_W'(EVENT_ENTRIES);

	logic    valid_s1;
	logic    op_s1;
	byte_t   byte_s1;
	expect_t kind_s1;

	expect_t expect_q, expect_d;
	parse_t  parse_q, parse_d;
	sync_t   sync_q, sync_d;
	entry_t  entry_q, entry_d, entry_inc;
	rec_t    rec_q, rec_d;

	logic    sv, done;
	byte_t   sb, vd;
	vkind_t  vk;

	logic    advance;
	logic    in_take;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= opcode;
			byte_s1 <= data_byte;
			kind_s1 <= expect_kind;
		end
	end

	always_comb begin
		expect_d  = expect_q;
		parse_d   = parse_q;
		sync_d    = sync_q;
		entry_d   = entry_q;
		rec_d     = rec_q;
		sv        = 1'b0;
		sb        = '0;
		vk        = VK_NONE;
		vd        = '0;
		done      = 1'b0;
		entry_inc = (entry_q == '1) ? entry_q : entry_q + ENTRY_W'(1);
		if (op_s1 == OP_SET_EXPECT) begin
			expect_d = kind_s1;
		end else begin
			unique case (parse_q)
				PS_IDLE: begin
					if (byte_s1 == ALL_ON) begin
						parse_d = PS_SYNC;
						sync_d  = SYNC_W'(1);
					end
				end
				PS_SYNC: begin
					if (byte_s1 == ALL_ON) begin
						if (sync_q != SYNC_MAX) begin
							sync_d = sync_q + SYNC_W'(1);
						end
					end else if (sync_q >= SYNC_MIN) begin
						sync_d = '0;
						sv     = 1'b1;
						sb     = byte_s1;
						unique case (expect_q)
							EX_IDLE: parse_d = PS_IDLE;
							EX_ACK: begin
								done     = 1'b1;
								expect_d = EX_IDLE;
								parse_d  = PS_IDLE;
							end
							EX_ACK_UPLOAD: begin
								parse_d  = PS_IDLE;
								expect_d = EX_UPLOAD;
							end
							EX_CLOCK, EX_UPLOAD: parse_d = PS_STATUS;
							EX_GRAPHICS, EX_EVENTS: begin
								parse_d = PS_STATUS;
								entry_d = '0;
							end
							default: begin
								expect_d = EX_IDLE;
								parse_d  = PS_IDLE;
							end
						endcase
					end else begin
						sync_d  = '0;
						parse_d = PS_IDLE;
					end
				end
				PS_STATUS: begin
					priority if (expect_q == EX_UPLOAD) begin
						parse_d = PS_HOUSE;
					end else if (expect_q == EX_CLOCK) begin
						vk      = VK_MINUTE;
						vd      = byte_s1;
						parse_d = PS_MINUTE;
					end else if (expect_q == EX_GRAPHICS) begin
						if (byte_s1 == ALL_ON) begin
							entry_d = entry_inc;
							parse_d = PS_ICON2;
						end else begin
							parse_d = PS_ICON1;
						end
					end else if (expect_q == EX_EVENTS) begin
						if (byte_s1 == ALL_ON) begin
							entry_d = entry_inc;
							parse_d = PS_EVENT8;
						end else begin
							rec_d   = REC_W'(1);
							parse_d = PS_EVENT1;
						end
					end else begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end
				end
				PS_HOUSE, PS_UNITS1: begin
					if (expect_q == EX_UPLOAD) begin
						parse_d = (parse_q == PS_HOUSE) ? PS_UNITS1 : PS_UNITS2;
					end else begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end
				end
				PS_UNITS2, PS_DAY: begin
					if ((parse_q == PS_UNITS2 && expect_q == EX_UPLOAD) ||
					    (parse_q == PS_DAY && expect_q == EX_CLOCK)) begin
						vk      = VK_HOUSE;
						vd      = {4'h0, byte_s1[7:4]};
						parse_d = PS_BASE;
					end else begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end
				end
				PS_BASE: begin
					done     = (expect_q == EX_UPLOAD) || (expect_q == EX_CLOCK);
					expect_d = EX_IDLE;
					parse_d  = PS_IDLE;
				end
				PS_MINUTE, PS_HOUR: begin
					if (expect_q == EX_CLOCK) begin
						vk      = (parse_q == PS_MINUTE) ? VK_HOUR : VK_DAY;
						vd      = byte_s1;
						parse_d = (parse_q == PS_MINUTE) ? PS_HOUR : PS_DAY;
					end else begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end
				end
				PS_ICON1: begin
					if (expect_q == EX_GRAPHICS) begin
						parse_d = PS_ICON2;
					end else begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end
				end
				PS_ICON2: begin
					priority if (expect_q != EX_GRAPHICS) begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end else if (entry_q >= ICON_LIMIT) begin
						done     = 1'b1;
						entry_d  = '0;
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end else if (byte_s1 == ALL_ON) begin
						entry_d = entry_inc;
					end else begin
						parse_d = PS_ICON1;
					end
				end
				PS_EVENT1: begin
					priority if (expect_q != EX_EVENTS) begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end else if (rec_q == RECORD_BYTES) begin
						parse_d = PS_EVENT8;
					end else begin
						rec_d = rec_q + REC_W'(1);
					end
				end
				PS_EVENT8: begin
					priority if (expect_q != EX_EVENTS) begin
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end else if (entry_q >= EVENT_LIMIT) begin
						done     = 1'b1;
						entry_d  = '0;
						expect_d = EX_IDLE;
						parse_d  = PS_IDLE;
					end else if (byte_s1 == ALL_ON) begin
						entry_d = entry_inc;
					end else begin
						rec_d   = REC_W'(1);
						parse_d = PS_EVENT1;
					end
				end
				default: parse_d = PS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= EX_IDLE;
			parse_q  <= PS_IDLE;
			sync_q   <= '0;
			entry_q  <= '0;
			rec_q    <= '0;
		end else if (advance) begin
			expect_q <= expect_d;
			parse_q  <= parse_d;
			sync_q   <= sync_d;
			entry_q  <= entry_d;
			rec_q    <= rec_d;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && op_s1 == OP_BYTE) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && op_s1 == OP_BYTE) begin
			status_valid <= sv;
			status_byte  <= sb;
			value_kind   <= vk;
			value_data   <= vd;
			complete     <= done;
		end
	end

	`ASSERT_CLK(a_stall_cause, in_stall |-> (out_valid && out_stall), "stall, no held word")
	`ASSERT_CLK(a_status_alone, out_valid && status_valid |-> value_kind == VK_NONE, "status alone")
	`ASSERT_CLK(a_status_zero, out_valid && !status_valid |-> status_byte == '0, "status zero")
	`ASSERT_CLK(a_value_zero, out_valid && value_kind == VK_NONE |-> value_data == '0, "value zero")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (parse_q == PS_IDLE || arst_n), "reset idle")

endmodule
`default_nettype wire
